// ===== rtl/solar_pump_pwm_ramp_control_macros.svh =====
// ----------------------------------------------------------------------------
// Solar pump PWM ramp control: assertion macros
// Concurrent assertion shorthands. Define ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef SOLAR_PUMP_PWM_RAMP_CONTROL_MACROS_SVH
`define SOLAR_PUMP_PWM_RAMP_CONTROL_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define SPPRC_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SPPRC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define SPPRC_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define SPPRC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== rtl/spprc_pkg.sv =====
// ----------------------------------------------------------------------------
// Solar pump PWM ramp control: package
// Fixed-point constants, register indexes and controller/datapath interface.
// ----------------------------------------------------------------------------
package spprc_pkg;

	localparam int unsigned PWM_MAX_DEF = 255;
	localparam int DUTY_W = 17;

	// duty values are fractions of 65536
	localparam logic [DUTY_W-1:0] ONE_FIX   = 17'd65536;
	localparam logic [DUTY_W-1:0] LOW_FIX   = 17'd6554;   // 10%
	localparam logic [DUTY_W-1:0] START_FIX = 17'd9830;   // 15%
	localparam logic [DUTY_W-1:0] MAX_TGT   = 17'd58982;  // 15% + 75%

	// ramp step = ramp*65536/100 = ramp*655 + floor(ramp*36/100)
	localparam logic [9:0]  STEP_INT   = 10'd655;
	localparam logic [17:0] STEP_FRAC  = 18'd188748;  // 36 * ceil(2^19/100)
	localparam int          STEP_SHIFT = 19;

	localparam int DIV_STEPS = 16;
	localparam int CNT_W     = $clog2(DIV_STEPS);

	typedef enum logic [1:0] {
		CFG_ON   = 2'd0,
		CFG_OFF  = 2'd1,
		CFG_SPAN = 2'd2,
		CFG_RAMP = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic load;      // capture request, precompute ramp step
		logic decide;    // pick branch, seed divider
		logic div_step;  // one quotient bit
		logic tgt;       // target from quotient
		logic duty;      // duty update
		logic pwm;       // PWM product
		logic out_load;  // fill result register
	} dp_cmd_t;

	typedef struct packed {
		logic run;       // target must be recomputed
		logic sat;       // ratio saturates, skip division
		logic out_free;  // result register can take a new value
	} dp_stat_t;

endpackage

// ===== rtl/solar_pump_pwm_ramp_control.sv =====
// ----------------------------------------------------------------------------
// Solar pump PWM ramp control: top level
// Turns temperature-difference samples into a ramped pump duty and PWM level.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, solar_delta) takes one signed sample per
//   request; output channel (out_valid/out_ready) returns pwm_level, duty_now
//   and duty_target for each request, in order.
//   Configuration is a plain write port (cfg_we, cfg_idx, cfg_data); write it
//   only while no request is in flight.
//   From accept to out_valid a request passes decide, PWM and output when
//   the pump is off, held or in the 10% band; decide, target, duty, PWM and
//   output when the speed ratio saturates; decide, the radix-2 divider,
//   target, duty, PWM and output when the ratio is computed. in_ready rises
//   together with out_valid, so a new request is taken only after the last.
//   A single result register sits on the output; a stalled receiver holds
//   the block in its final step until that register frees up, while the
//   finished result stays stable on the ports.
//   Reset clears duty and target to zero, loads register defaults (on 0,
//   off 0, span 1, ramp 1%) and empties the output.
// ----------------------------------------------------------------------------
module solar_pump_pwm_ramp_control import spprc_pkg::*; #(
	parameter int unsigned PWM_MAX = PWM_MAX_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] solar_delta,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [7:0]         pwm_level,
	output logic [DUTY_W-1:0]  duty_now,
	output logic [DUTY_W-1:0]  duty_target,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_idx,
	input  logic [15:0]        cfg_data
);

	logic signed [15:0] on_delta_q;
	logic signed [15:0] off_delta_q;
	logic signed [15:0] span_delta_q;
	logic [6:0]         ramp_pct_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			on_delta_q   <= 16'sd0;
			off_delta_q  <= 16'sd0;
			span_delta_q <= 16'sd1;
			ramp_pct_q   <= 7'd1;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_ON:   on_delta_q   <= cfg_data;
				CFG_OFF:  off_delta_q  <= cfg_data;
				CFG_SPAN: span_delta_q <= cfg_data;
				CFG_RAMP: ramp_pct_q   <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	dp_cmd_t  cmd;
	dp_stat_t stat;

	spprc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	spprc_dp #(
		.PWM_MAX (PWM_MAX)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.solar_delta (solar_delta),
		.on_delta    (on_delta_q),
		.off_delta   (off_delta_q),
		.span_delta  (span_delta_q),
		.ramp_pct    (ramp_pct_q),
		.out_ready   (out_ready),
		.out_valid   (out_valid),
		.pwm_level   (pwm_level),
		.duty_now    (duty_now),
		.duty_target (duty_target)
	);

endmodule

// ===== rtl/spprc_ctrl.sv =====
// ----------------------------------------------------------------------------
// Solar pump PWM ramp control: controller
// Sequences decision, serial division, target and duty update, PWM and output.
// ----------------------------------------------------------------------------
`include "solar_pump_pwm_ramp_control_macros.svh"

module spprc_ctrl import spprc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_DECIDE = 7'b0000010,
		ST_DIV    = 7'b0000100,
		ST_TGT    = 7'b0001000,
		ST_DUTY   = 7'b0010000,
		ST_PWM    = 7'b0100000,
		ST_OUT    = 7'b1000000
	} state_t;

	state_t           state_q, state_d;
	logic [CNT_W-1:0] cnt_q;
	logic             div_last;

	assign div_last = (cnt_q == CNT_W'(DIV_STEPS - 1));

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				if (!stat.run)    state_d = ST_PWM;
				else if (stat.sat) state_d = ST_TGT;
				else               state_d = ST_DIV;
			end
			ST_DIV: begin
				if (div_last) state_d = ST_TGT;
			end
			ST_TGT:  state_d = ST_DUTY;
			ST_DUTY: state_d = ST_PWM;
			ST_PWM:  state_d = ST_OUT;
			ST_OUT: begin
				if (stat.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DIV) cnt_q <= cnt_q + CNT_W'(1);
			else                   cnt_q <= '0;
		end
	end

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd          = '0;
		cmd.load     = in_valid && (state_q == ST_IDLE);
		cmd.decide   = (state_q == ST_DECIDE);
		cmd.div_step = (state_q == ST_DIV);
		cmd.tgt      = (state_q == ST_TGT);
		cmd.duty     = (state_q == ST_DUTY);
		cmd.pwm      = (state_q == ST_PWM);
		cmd.out_load = (state_q == ST_OUT) && stat.out_free;
	end

	`SPPRC_ASSERT_NEXT(a_accept_decide, clk, arst_n, in_valid && in_ready,
		state_q == ST_DECIDE, "accepted request did not move to decide")
	`SPPRC_ASSERT_IMPLY(a_cnt_idle, clk, arst_n, state_q != ST_DIV,
		cnt_q == '0, "division counter running outside division")
	`SPPRC_ASSERT_NEXT(a_out_done, clk, arst_n, cmd.out_load,
		state_q == ST_IDLE && in_ready, "controller not idle after result load")

endmodule

// ===== rtl/spprc_dp.sv =====
// ----------------------------------------------------------------------------
// Solar pump PWM ramp control: datapath
// Duty/target state, radix-2 restoring divider, ramp logic, PWM scaling and
// the result register.
// ----------------------------------------------------------------------------
`include "solar_pump_pwm_ramp_control_macros.svh"

module spprc_dp import spprc_pkg::*; #(
	parameter int unsigned PWM_MAX = PWM_MAX_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  dp_cmd_t            cmd,
	output dp_stat_t           stat,
	input  logic signed [15:0] solar_delta,
	input  logic signed [15:0] on_delta,
	input  logic signed [15:0] off_delta,
	input  logic signed [15:0] span_delta,
	input  logic [6:0]         ramp_pct,
	input  logic               out_ready,
	output logic               out_valid,
	output logic [7:0]         pwm_level,
	output logic [DUTY_W-1:0]  duty_now,
	output logic [DUTY_W-1:0]  duty_target
);

	localparam int PMW    = $clog2(PWM_MAX + 1);
	localparam int PROD_W = (DUTY_W + PMW + 1 > 24) ? DUTY_W + PMW + 1 : 24;

	logic signed [15:0] delta_q;
	logic [DUTY_W-1:0]  step_q;
	logic [15:0]        rem_q;
	logic [DUTY_W-1:0]  quo_q;
	logic [DUTY_W-1:0]  tgt_q;
	logic [DUTY_W-1:0]  duty_q;
	logic [PROD_W-1:0]  prod_q;
	logic               out_valid_q;
	logic [7:0]         pwm_level_q;
	logic [DUTY_W-1:0]  duty_now_q;
	logic [DUTY_W-1:0]  duty_target_q;

	// ramp step, precomputed at request capture
	logic [DUTY_W-1:0] step_int;
	logic [24:0]       step_frac;
	logic [DUTY_W-1:0] step_d;

	assign step_int  = DUTY_W'(ramp_pct) * DUTY_W'(STEP_INT);
	assign step_frac = 25'(ramp_pct) * 25'(STEP_FRAC);
	assign step_d    = step_int + DUTY_W'(step_frac >> STEP_SHIFT);

	// branch decision
	logic        below_off, le_on, duty_zero, prep, run, span_pos, sat;
	logic [16:0] diff_full;
	logic [15:0] diff;

	assign below_off = delta_q < off_delta;
	assign le_on     = delta_q <= on_delta;
	assign duty_zero = (duty_q == '0);
	assign prep      = le_on && duty_zero;
	assign run       = !below_off && !prep && (!le_on || duty_q >= START_FIX);
	assign diff_full = {delta_q[15], delta_q} - {off_delta[15], off_delta};
	assign diff      = diff_full[15:0];
	assign span_pos  = !span_delta[15] && (span_delta != '0);
	// diff at or above span, or a span not above zero, saturates to exactly 1.0
	assign sat       = !span_pos || (diff >= span_delta[15:0]);

	// divider step
	logic [16:0] rem_x2;
	logic        q_bit;

	assign rem_x2 = {rem_q, 1'b0};
	assign q_bit  = rem_x2 >= {1'b0, span_delta[15:0]};

	// target = 15% + 3q/4
	logic [18:0] tri_q;
	assign tri_q = {2'b00, quo_q} + {1'b0, quo_q, 1'b0};

	logic [DUTY_W-1:0] gap;
	assign gap = tgt_q - duty_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duty_q <= '0;
			tgt_q  <= '0;
		end else begin
			if (cmd.decide) begin
				if (below_off) begin
					duty_q <= '0;
					tgt_q  <= '0;
				end else if (prep) begin
					duty_q <= LOW_FIX;
					tgt_q  <= LOW_FIX;
				end
			end
			if (cmd.tgt) tgt_q <= START_FIX + DUTY_W'(tri_q >> 2);
			if (cmd.duty) begin
				if (duty_q < START_FIX)  duty_q <= START_FIX;
				else if (tgt_q < duty_q) duty_q <= tgt_q;
				else if (gap < step_q)   duty_q <= tgt_q;
				else                     duty_q <= duty_q + step_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			delta_q <= solar_delta;
			step_q  <= step_d;
		end
		if (cmd.decide) begin
			rem_q <= diff;
			quo_q <= sat ? ONE_FIX : '0;
		end
		if (cmd.div_step) begin
			rem_q <= q_bit ? 16'(rem_x2 - {1'b0, span_delta[15:0]}) : rem_x2[15:0];
			quo_q <= {quo_q[DUTY_W-2:0], q_bit};
		end
		if (cmd.pwm)
			prod_q <= PROD_W'(duty_q) * PROD_W'(PWM_MAX) + PROD_W'(32768);
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)           out_valid_q <= 1'b0;
		else if (cmd.out_load) out_valid_q <= 1'b1;
		else if (out_ready)    out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			pwm_level_q   <= prod_q[23:16];
			duty_now_q    <= duty_q;
			duty_target_q <= tgt_q;
		end
	end

	assign stat.run      = run;
	assign stat.sat      = sat;
	assign stat.out_free = !out_valid_q || out_ready;

	assign out_valid   = out_valid_q;
	assign pwm_level   = pwm_level_q;
	assign duty_now    = duty_now_q;
	assign duty_target = duty_target_q;

	`SPPRC_ASSERT_IMPLY(a_duty_max, clk, arst_n, 1'b1, duty_q <= MAX_TGT,
		"duty above 90 percent")
	`SPPRC_ASSERT_IMPLY(a_tgt_max, clk, arst_n, 1'b1, tgt_q <= MAX_TGT,
		"target above 90 percent")
	`SPPRC_ASSERT_IMPLY(a_rem_range, clk, arst_n, cmd.div_step,
		rem_q < span_delta[15:0], "divider remainder not below span")

endmodule
